/* rtl/mandelbrot_escape_time_unit_macros.svh */
// Assertion helpers shared by the escape-time modules.
// Both expect clk and rst in scope.
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_MACROS_SVH

// Checked outside reset only.
`define MBE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define MBE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mbe_pkg.sv */
package mbe_pkg;

  localparam int Q_W       = 48;   // Q8.40 word
  localparam int FRAC_W    = 40;
  localparam int SUM_W     = 58;   // wide enough for any sum before saturation
  localparam int PROD_W    = 57;   // signed product out of the multiplier
  localparam int MAG_W     = 56;   // product magnitude after scaling
  localparam int HALF_W    = 24;   // multiplier operand width
  localparam int ACC_W     = 96;
  localparam int CNT_W     = 21;
  localparam int OFS_W     = 12;
  localparam int STEP_W    = 41;
  localparam int CFG_W     = 48;
  localparam int IDX_W     = 3;
  localparam int PAL_OUT_W = 9;

  localparam int PALETTE_SIZE_DEF = 512;

  localparam logic [IDX_W-1:0] REG_CENTER_X   = 3'd0;
  localparam logic [IDX_W-1:0] REG_CENTER_Y   = 3'd1;
  localparam logic [IDX_W-1:0] REG_PIXEL_STEP = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_ITER   = 3'd3;

  localparam logic [STEP_W-1:0] PIXEL_STEP_RST = 41'd4398046511;
  localparam logic [CNT_W-1:0]  MAX_ITER_RST   = 21'd96;

  typedef struct packed {
    logic              start;
    logic [Q_W-1:0]    a_mag;
    logic [Q_W-1:0]    b_mag;
    logic              neg;
    logic              frac;   // scale by 2^-40 when set
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic signed [Q_W-1:0] center_x;
    logic signed [Q_W-1:0] center_y;
    logic [STEP_W-1:0]     pixel_step;
    logic [CNT_W-1:0]      max_iterations;
  } cfg_t;

endpackage

/* rtl/mbe_mul.sv */
`include "mandelbrot_escape_time_unit_macros.svh"

module mbe_mul (
  input  logic             clk,
  input  logic             rst,
  input  mbe_pkg::mul_req_t req,
  output mbe_pkg::mul_rsp_t rsp
);
  import mbe_pkg::*;

  localparam logic [1:0] SH_0 = 2'd0;
  localparam logic [1:0] SH_1 = 2'd1;
  localparam logic [1:0] SH_2 = 2'd2;

  logic [Q_W-1:0]           opa;
  logic [Q_W-1:0]           opb;
  logic                     neg_r;
  logic                     frac_r;
  logic                     issuing;
  logic [1:0]               cnt;
  logic [2*HALF_W-1:0]      pp;
  logic [1:0]               pp_sh;
  logic                     pp_valid;
  logic                     pp_last;
  logic [ACC_W-1:0]         acc;
  logic                     fin;
  logic                     done;
  logic signed [PROD_W-1:0] prod;
  logic [HALF_W-1:0]        mx;
  logic [HALF_W-1:0]        my;
  logic [1:0]               sh_sel;
  logic [ACC_W-1:0]         addend;
  logic [MAG_W-1:0]         m;
  logic                     busy;

  // Partial product order: lo*lo, lo*hi, hi*lo, hi*hi.
  always_comb begin
    unique case (cnt)
      2'd0: begin
        mx = opa[HALF_W-1:0];
        my = opb[HALF_W-1:0];
        sh_sel = SH_0;
      end
      2'd1: begin
        mx = opa[HALF_W-1:0];
        my = opb[Q_W-1:HALF_W];
        sh_sel = SH_1;
      end
      2'd2: begin
        mx = opa[Q_W-1:HALF_W];
        my = opb[HALF_W-1:0];
        sh_sel = SH_1;
      end
      default: begin
        mx = opa[Q_W-1:HALF_W];
        my = opb[Q_W-1:HALF_W];
        sh_sel = SH_2;
      end
    endcase
  end

  always_comb begin
    unique case (pp_sh)
      SH_0:    addend = ACC_W'(pp);
      SH_1:    addend = ACC_W'(pp) << HALF_W;
      SH_2:    addend = ACC_W'(pp) << (2 * HALF_W);
      default: addend = '0;
    endcase
  end

  assign m    = frac_r ? acc[ACC_W-1:FRAC_W] : acc[MAG_W-1:0];
  assign busy = issuing | pp_valid | fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing  <= 1'b0;
      cnt      <= '0;
      pp_valid <= 1'b0;
      pp_last  <= 1'b0;
      fin      <= 1'b0;
      done     <= 1'b0;
    end else begin
      done     <= fin;
      fin      <= pp_valid & pp_last;
      pp_valid <= issuing;
      pp_last  <= issuing && (cnt == 2'd3);
      if (req.start) begin
        issuing <= 1'b1;
        cnt     <= '0;
      end else if (issuing) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          issuing <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      opa    <= req.a_mag;
      opb    <= req.b_mag;
      neg_r  <= req.neg;
      frac_r <= req.frac;
      acc    <= '0;
    end else if (pp_valid) begin
      acc <= acc + addend;
    end
    if (issuing) begin
      pp    <= (2*HALF_W)'(mx) * (2*HALF_W)'(my);
      pp_sh <= sh_sel;
    end
    // apply sign once the magnitude is complete
    if (fin) begin
      prod <= neg_r ? -$signed({1'b0, m}) : $signed({1'b0, m});
    end
  end

  assign rsp.done = done;
  assign rsp.prod = prod;

  `MBE_ASSERT(a_mul_start_idle, req.start |-> !busy, "multiplier started while busy")
  `MBE_ASSERT(a_mul_latency, req.start |-> ##7 rsp.done, "product not ready seven cycles after start")
  `MBE_ASSERT(a_mul_done_pulse, rsp.done |=> !rsp.done, "product flag held longer than one cycle")

endmodule

/* rtl/mbe_seq.sv */
`include "mandelbrot_escape_time_unit_macros.svh"

module mbe_seq #(
  parameter int PALETTE_SIZE = mbe_pkg::PALETTE_SIZE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mbe_pkg::cfg_t                        cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [mbe_pkg::OFS_W-1:0]     pixel_dx,
  input  logic signed [mbe_pkg::OFS_W-1:0]     pixel_dy,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mbe_pkg::CNT_W-1:0]            escape_count,
  output logic                                 inside_set,
  output logic [mbe_pkg::PAL_OUT_W-1:0]        palette_index,
  output mbe_pkg::mul_req_t                    mreq,
  input  mbe_pkg::mul_rsp_t                    mrsp
);
  import mbe_pkg::*;

  localparam int PW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam logic [Q_W-1:0] QMAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [Q_W-1:0] QMIN = 48'h8000_0000_0000;
  localparam logic [Q_W:0]   ESC_LIM = 49'h800_0000_0000;  // 8.0 in Q8.40

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_CX   = 10'b00_0000_0010,
    S_CY   = 10'b00_0000_0100,
    S_SQA  = 10'b00_0000_1000,
    S_SQB  = 10'b00_0001_0000,
    S_TEST = 10'b00_0010_0000,
    S_AB   = 10'b00_0100_0000,
    S_ADD1 = 10'b00_1000_0000,
    S_ADD2 = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } state_t;

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'($signed(QMAX));
    lo = SUM_W'($signed(QMIN));
    if (v > hi) begin
      return $signed(QMAX);
    end else if (v < lo) begin
      return $signed(QMIN);
    end
    return $signed(v[Q_W-1:0]);
  endfunction

  function automatic logic [Q_W-1:0] mag_q(input logic signed [Q_W-1:0] v);
    if (v[Q_W-1]) begin
      return Q_W'(-v);
    end
    return v;
  endfunction

  state_t                   state;
  state_t                   state_next;
  logic                     issued;
  logic signed [OFS_W-1:0]  dx;
  logic signed [OFS_W-1:0]  dy;
  logic signed [Q_W-1:0]    cx;
  logic signed [Q_W-1:0]    cy;
  logic signed [Q_W-1:0]    a;
  logic signed [Q_W-1:0]    b;
  logic signed [Q_W-1:0]    aa;
  logic signed [Q_W-1:0]    bb;
  logic signed [Q_W-1:0]    ab;
  logic signed [Q_W-1:0]    t1;
  logic signed [Q_W-1:0]    t2;
  logic [CNT_W-1:0]         n;
  logic [PW-1:0]            pal;
  logic                     first;
  logic                     inside_r;
  logic                     is_mul;
  logic                     out_load;
  logic                     esc;
  logic                     last;
  logic [Q_W:0]             esc_sum;
  logic [CNT_W:0]           n_inc;
  logic [CNT_W-1:0]         lim;
  logic [PW-1:0]            pal_inc;
  logic [OFS_W-1:0]         ofs_mag;
  logic signed [OFS_W-1:0]  ofs;
  logic signed [Q_W-1:0]    prod_q;
  logic signed [Q_W-1:0]    ofs_c;

  assign is_mul   = (state == S_CX) || (state == S_CY) || (state == S_SQA) ||
                    (state == S_SQB) || (state == S_AB);
  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  assign lim     = (cfg.max_iterations == '0) ? CNT_W'(1) : cfg.max_iterations;
  assign esc_sum = {1'b0, aa} + {1'b0, bb};
  assign esc     = esc_sum > ESC_LIM;
  assign n_inc   = (CNT_W+1)'(n) + (CNT_W+1)'(1);
  assign last    = n_inc >= (CNT_W+1)'(lim);
  assign pal_inc = (pal == PW'(PALETTE_SIZE - 1)) ? '0 : pal + PW'(1);

  assign ofs     = (state == S_CY) ? dy : dx;
  assign ofs_mag = ofs[OFS_W-1] ? OFS_W'(-ofs) : ofs;
  assign prod_q  = sat_q(SUM_W'(mrsp.prod));
  assign ofs_c   = sat_q(SUM_W'((state == S_CY) ? cfg.center_y : cfg.center_x) +
                         SUM_W'(mrsp.prod));

  // Operand select for the shared multiplier.
  always_comb begin
    mreq.start = is_mul && !issued;
    unique case (state)
      S_CX, S_CY: begin
        mreq.a_mag = Q_W'(ofs_mag);
        mreq.b_mag = Q_W'(cfg.pixel_step);
        mreq.neg   = ofs[OFS_W-1];
        mreq.frac  = 1'b0;
      end
      S_SQA: begin
        mreq.a_mag = mag_q(a);
        mreq.b_mag = mag_q(a);
        mreq.neg   = 1'b0;
        mreq.frac  = 1'b1;
      end
      S_SQB: begin
        mreq.a_mag = mag_q(b);
        mreq.b_mag = mag_q(b);
        mreq.neg   = 1'b0;
        mreq.frac  = 1'b1;
      end
      S_AB: begin
        mreq.a_mag = mag_q(a);
        mreq.b_mag = mag_q(b);
        mreq.neg   = a[Q_W-1] ^ b[Q_W-1];
        mreq.frac  = 1'b1;
      end
      default: begin
        mreq.a_mag = '0;
        mreq.b_mag = '0;
        mreq.neg   = 1'b0;
        mreq.frac  = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_CX;
      S_CX:   if (mrsp.done) state_next = S_CY;
      S_CY:   if (mrsp.done) state_next = S_SQA;
      S_SQA:  if (mrsp.done) state_next = S_SQB;
      S_SQB:  if (mrsp.done) state_next = S_TEST;
      S_TEST: begin
        priority if (first) state_next = S_AB;
        else if (esc || last) state_next = S_DONE;
        else state_next = S_AB;
      end
      S_AB:   if (mrsp.done) state_next = S_ADD1;
      S_ADD1: state_next = S_ADD2;
      S_ADD2: state_next = S_SQA;
      S_DONE: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (is_mul && mrsp.done) begin
        issued <= 1'b0;
      end else if (mreq.start) begin
        issued <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          dx <= pixel_dx;
          dy <= pixel_dy;
        end
      end
      S_CX: if (mrsp.done) cx <= ofs_c;
      S_CY: begin
        if (mrsp.done) begin
          cy    <= ofs_c;
          a     <= cx;
          b     <= ofs_c;
          n     <= '0;
          pal   <= '0;
          first <= 1'b1;
        end
      end
      S_SQA: if (mrsp.done) aa <= prod_q;
      S_SQB: if (mrsp.done) bb <= prod_q;
      S_TEST: begin
        // first pass only primes the squares of c
        priority if (first) begin
          first <= 1'b0;
        end else if (esc) begin
          inside_r <= 1'b0;
        end else begin
          n        <= n_inc[CNT_W-1:0];
          pal      <= pal_inc;
          inside_r <= last;
        end
      end
      S_AB: if (mrsp.done) ab <= prod_q;
      S_ADD1: begin
        t1 <= sat_q(SUM_W'(aa) - SUM_W'(bb));
        t2 <= sat_q(SUM_W'(ab) + SUM_W'(ab));
      end
      S_ADD2: begin
        a <= sat_q(SUM_W'(t1) + SUM_W'(cx));
        b <= sat_q(SUM_W'(t2) + SUM_W'(cy));
      end
      S_DONE: begin
        if (out_load) begin
          escape_count  <= n;
          inside_set    <= inside_r;
          palette_index <= inside_r ? '0 : PAL_OUT_W'(pal);
        end
      end
      default: ;
    endcase
  end

  `MBE_ASSERT(a_seq_accept_busy, in_valid && in_ready |=> !in_ready, "took a second word while busy")
  `MBE_ASSERT(a_seq_done_in_mul, mrsp.done |-> is_mul && issued, "product arrived outside a multiply step")
  `MBE_ASSERT(a_seq_start_once, mreq.start |=> !mreq.start, "multiplier started twice in a row")
  `MBE_ASSERT(a_seq_inside_black, out_valid && inside_set |-> palette_index == '0, "inside point with nonzero palette index")
  `MBE_ASSERT_ALWAYS(a_seq_reset, rst |=> !out_valid && in_ready, "reset did not return to idle")

endmodule

/* rtl/mandelbrot_escape_time_unit.sv */
// One pixel at a time: no new input word is taken until the result of the last one
// is loaded into the output registers. A pixel takes escape_count + 1 z updates on
// escape, otherwise as many as the iteration limit; every product goes through the
// shared 24x24 multiplier (four partial products), three products per iteration.
// Reset: synchronous, active high; clears control, loads register defaults.
module mandelbrot_escape_time_unit #(
  parameter int PALETTE_SIZE = mbe_pkg::PALETTE_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mbe_pkg::IDX_W-1:0]         cfg_index,
  input  logic [mbe_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [mbe_pkg::OFS_W-1:0]  pixel_dx,
  input  logic signed [mbe_pkg::OFS_W-1:0]  pixel_dy,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mbe_pkg::CNT_W-1:0]         escape_count,
  output logic                              inside_set,
  output logic [mbe_pkg::PAL_OUT_W-1:0]     palette_index
);
  import mbe_pkg::*;

  cfg_t     cfg;
  mul_req_t mreq;
  mul_rsp_t mrsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x       <= '0;
      cfg.center_y       <= '0;
      cfg.pixel_step     <= PIXEL_STEP_RST;
      cfg.max_iterations <= MAX_ITER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X:   cfg.center_x       <= $signed(cfg_data[Q_W-1:0]);
        REG_CENTER_Y:   cfg.center_y       <= $signed(cfg_data[Q_W-1:0]);
        REG_PIXEL_STEP: cfg.pixel_step     <= cfg_data[STEP_W-1:0];
        REG_MAX_ITER:   cfg.max_iterations <= cfg_data[CNT_W-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  mbe_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  mbe_seq #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pixel_dx      (pixel_dx),
    .pixel_dy      (pixel_dy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .escape_count  (escape_count),
    .inside_set    (inside_set),
    .palette_index (palette_index),
    .mreq          (mreq),
    .mrsp          (mrsp)
  );

endmodule

/* dv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mbe_pkg::*;

  localparam int     PALETTE_SIZE  = PALETTE_SIZE_DEF;
  localparam longint Q_MAX         = (longint'(1) <<< (Q_W - 1)) - 1;
  localparam longint Q_MIN         = -Q_MAX - 1;
  localparam longint Q_ONE         = longint'(1) <<< FRAC_W;
  localparam longint ESCAPE_SUM    = 8 * Q_ONE;
  localparam int     RANDOM_ITEMS  = 1825;
  localparam int     HOLD_CYCLES   = 600;
  localparam int     SETTLE_CYCLES = 200;
  localparam int     MAX_SHOWN     = 10;

  typedef struct packed {
    logic [CNT_W-1:0]     count;
    logic                 in_set;
    logic [PAL_OUT_W-1:0] palette;
  } escape_t;

  typedef struct packed {
    logic signed [OFS_W-1:0] dx;
    logic signed [OFS_W-1:0] dy;
    escape_t                 want;
  } pixel_expect_t;

  class escape_scoreboard;
    cfg_t          view;
    pixel_expect_t expected_escapes[$];
    int            errors;

    function new();
      view.center_x       = '0;
      view.center_y       = '0;
      view.pixel_step     = PIXEL_STEP_RST;
      view.max_iterations = MAX_ITER_RST;
      errors              = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_CENTER_X:   view.center_x = data;
        REG_CENTER_Y:   view.center_y = data;
        REG_PIXEL_STEP: view.pixel_step = data[STEP_W-1:0];
        REG_MAX_ITER:   view.max_iterations = data[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function longint sat_q(longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
    endfunction

    // exact product, magnitude truncated by the fraction width, then saturated
    function longint qmul(longint x, longint y);
      logic [95:0]     ux, uy, prod;
      longint unsigned mag;
      ux   = 96'(x < 0 ? -x : x);
      uy   = 96'(y < 0 ? -y : y);
      prod = ux * uy;
      mag  = 64'(prod >> FRAC_W);
      if ((x < 0) != (y < 0))
        return (mag > longint'(Q_MAX) + 1) ? Q_MIN : -longint'(mag);
      return (mag > Q_MAX) ? Q_MAX : longint'(mag);
    endfunction

    function escape_t compute_escape(logic signed [OFS_W-1:0] dx,
                                     logic signed [OFS_W-1:0] dy);
      longint          cx, cy, zr, zi, nr, ni;
      longint unsigned lim, n;
      logic            escaped;
      escape_t         res;
      cx  = sat_q(longint'(view.center_x) + longint'(dx) * longint'(view.pixel_step));
      cy  = sat_q(longint'(view.center_y) + longint'(dy) * longint'(view.pixel_step));
      lim = (view.max_iterations == 0) ? 1 : view.max_iterations;
      zr  = cx;
      zi  = cy;
      n   = 0;
      escaped = 1'b0;
      do begin
        nr = sat_q(sat_q(qmul(zr, zr) - qmul(zi, zi)) + cx);
        ni = sat_q(sat_q(2 * qmul(zr, zi)) + cy);
        zr = nr;
        zi = ni;
        if (qmul(zr, zr) + qmul(zi, zi) > ESCAPE_SUM) escaped = 1'b1;
        else n++;
      end while (!escaped && n < lim);
      res.count   = CNT_W'(n);
      res.in_set  = (n >= lim);
      res.palette = res.in_set ? '0 : PAL_OUT_W'(n % PALETTE_SIZE);
      return res;
    endfunction

    function void note_pixel(logic signed [OFS_W-1:0] dx, logic signed [OFS_W-1:0] dy);
      pixel_expect_t e;
      e.dx   = dx;
      e.dy   = dy;
      e.want = compute_escape(dx, dy);
      expected_escapes.push_back(e);
    endfunction

    function void check_result(logic [CNT_W-1:0] count, logic in_set,
                               logic [PAL_OUT_W-1:0] palette);
      pixel_expect_t e;
      if (expected_escapes.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("[%0t] unexpected word: count=%0d inside=%0b palette=%0d",
                   $time, count, in_set, palette);
        return;
      end
      e = expected_escapes.pop_front();
      if (e.want.count !== count || e.want.in_set !== in_set ||
          e.want.palette !== palette) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display({"[%0t] mismatch dx=%0d dy=%0d: expected count=%0d inside=%0b ",
                    "palette=%0d, got count=%0d inside=%0b palette=%0d"},
                   $time, e.dx, e.dy, e.want.count, e.want.in_set, e.want.palette,
                   count, in_set, palette);
      end
    endfunction

    function int pending();
      return expected_escapes.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [IDX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]        cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [OFS_W-1:0] pixel_dx;
  logic signed [OFS_W-1:0] pixel_dy;
  logic                    out_valid;
  logic                    out_ready;
  logic [CNT_W-1:0]        escape_count;
  logic                    inside_set;
  logic [PAL_OUT_W-1:0]    palette_index;

  escape_scoreboard sb;
  int               tx_gap_max = 9;
  int               rx_gap_max = 9;
  bit               hold_req   = 1'b0;

  mandelbrot_escape_time_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel_dx     (pixel_dx),
    .pixel_dy     (pixel_dy),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .escape_count (escape_count),
    .inside_set   (inside_set),
    .palette_index(palette_index)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic apply_config(input logic [CFG_W-1:0] cx, cy, pitch, lim,
                              input bit junk_writes);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_PIXEL_STEP, pitch);
    write_reg(REG_MAX_ITER, lim);
    // indexes past the last register must be dropped
    if (junk_writes)
      for (int i = int'(REG_MAX_ITER) + 1; i < 2 ** IDX_W; i++)
        write_reg(IDX_W'(i), CFG_W'({$urandom, $urandom}));
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(input int dx, input int dy);
    logic signed [OFS_W-1:0] px, py;
    int unsigned             gap;
    px  = OFS_W'(dx);
    py  = OFS_W'(dy);
    gap = $urandom_range(tx_gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_dx <= px;
    pixel_dy <= py;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(px, py);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // mostly views around the set with small limits, some wild words
  task automatic random_view();
    logic [CFG_W-1:0] cx, cy, pitch, lim;
    int unsigned      lim_val, pick;
    if ($urandom_range(9, 0) < 7) begin
      cx = CFG_W'((longint'($urandom_range(1 << 20, 0)) << 22)
                  + $urandom_range((1 << 22) - 1, 0) - 9 * (Q_ONE >>> 2));
      cy = CFG_W'((longint'($urandom_range(1 << 20, 0)) << 21)
                  + $urandom_range((1 << 21) - 1, 0) - Q_ONE);
    end else begin
      cx = CFG_W'({$urandom, $urandom});
      cy = CFG_W'({$urandom, $urandom});
    end
    if ($urandom_range(9, 0) < 7)
      pitch = CFG_W'((longint'(1) << $urandom_range(33, 16)) + $urandom_range(65535, 0));
    else
      pitch = CFG_W'({$urandom, $urandom});
    pick = $urandom_range(19, 0);
    if (pick == 0)       lim_val = 0;
    else if (pick < 16)  lim_val = $urandom_range(24, 1);
    else                 lim_val = $urandom_range(64, 25);
    lim = CFG_W'({$urandom, CNT_W'(lim_val)});
    if ($urandom_range(1, 0) == 0) lim[CFG_W-1:CNT_W] = '0;
    apply_config(cx, cy, pitch, lim, $urandom_range(3, 0) == 0);
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = $urandom_range(rx_gap_max, 0);
      if (hold_req) begin
        hold_req = 1'b0;
        stall += HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(escape_count, inside_set, palette_index);
    end
  end

  initial begin : stimulus
    int sent, round, burst, mode;
    sb        = new();
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    pixel_dx  <= '0;
    pixel_dy  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset view: corners, origin, points near the boundary
    send_pixel(0, 0);
    send_pixel(-2048, -2048);
    send_pixel(2047, 2047);
    send_pixel(-2048, 2047);
    send_pixel(2047, -2048);
    send_pixel(-1, -1);
    send_pixel(1, 0);
    send_pixel(-190, 0);
    send_pixel(100, 0);
    send_pixel(-500, 0);
    send_pixel(-120, 160);
    send_pixel(0, -2048);
    drain();

    // zero limit counts as one
    apply_config(CFG_W'(-(Q_ONE >>> 1)), '0, CFG_W'(PIXEL_STEP_RST), '0, 1'b1);
    send_pixel(0, 0);
    send_pixel(2047, 2047);
    drain();

    // huge limits, only with points far outside; zero step maps all to center
    apply_config(CFG_W'(100 * Q_ONE), CFG_W'(Q_MAX), '0, CFG_W'((1 << CNT_W) - 1), 1'b0);
    send_pixel(-2048, 2047);
    drain();
    apply_config('0, CFG_W'(Q_MIN), CFG_W'(1), CFG_W'(1 << 20), 1'b0);
    send_pixel(2047, -2048);
    drain();

    // unit step from the most negative corner: saturation and exact lattice points
    apply_config(CFG_W'(Q_MIN), CFG_W'(Q_MIN), CFG_W'(Q_ONE), CFG_W'(8), 1'b0);
    send_pixel(-2048, -2048);
    send_pixel(2047, 2047);
    send_pixel(128, 128);
    send_pixel(127, 128);
    drain();

    // all-ones words: step and limit drop their upper bits
    apply_config(CFG_W'(Q_MAX), '0, '1, {{(CFG_W - CNT_W){1'b1}}, CNT_W'(5)}, 1'b0);
    send_pixel(-64, 0);
    send_pixel(-2048, 2047);
    send_pixel(2047, -2048);
    drain();

    apply_config(CFG_W'(Q_MAX), CFG_W'(Q_MIN), CFG_W'(1), CFG_W'(3), 1'b0);
    send_pixel(-2048, -2048);
    send_pixel(2047, 2047);
    drain();

    sent  = 0;
    round = 0;
    while (sent < RANDOM_ITEMS) begin
      random_view();
      mode       = $urandom_range(3, 0);
      tx_gap_max = mode[0] ? 9 : 0;
      rx_gap_max = mode[1] ? 9 : 0;
      // stall the sink for a long stretch while words keep coming
      if (round == 1) hold_req = 1'b1;
      burst = $urandom_range(220, 80);
      if (burst > RANDOM_ITEMS - sent) burst = RANDOM_ITEMS - sent;
      repeat (burst) begin
        send_pixel($signed(OFS_W'($urandom)), $signed(OFS_W'($urandom)));
        sent++;
      end
      drain();
      round++;
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("** mandelbrot_escape_time_unit: PASSED **");
    else
      $display("** mandelbrot_escape_time_unit: FAILED **");
    $finish;
  end

  initial begin : watchdog
    #(150_000_000);
    $display("** mandelbrot_escape_time_unit: FAILED **");
    $finish;
  end

endmodule

/* mandelbrot_escape_time_unit.f */
+incdir+rtl
rtl/mbe_pkg.sv
rtl/mbe_mul.sv
rtl/mbe_seq.sv
rtl/mandelbrot_escape_time_unit.sv
dv/tb_top.sv
